@@ sv/rld_pkg.sv @@
package rld_pkg;

  localparam int unsigned BYTE_W = 8;

  // Source of the next word loaded into the output register
  typedef enum logic [1:0] {
    OUT_BYTE  = 2'd0,
    OUT_EMPTY = 2'd1,
    OUT_RUN   = 2'd2
  } out_sel_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic     out_load;
    out_sel_e out_sel;
    logic     out_last;
    logic     out_trunc;
    logic     cnt_load;
    logic     cnt_dec;
    logic     cnt_clear;
    logic     run_cap;
    logic     run_step;
  } rld_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic enable;
    logic slot_free;
    logic cnt_is_one;
    logic run_le_lanes;
    logic ctl_is_rep;
  } rld_stat_t;

endpackage

@@ sv/run_length_decoder_core.sv @@
// Channel   Direction  tdata                                   tlast          tuser
// s_axis    in         [7:0] in_byte                           end_of_stream  -
// m_axis    out        [8L-1:0] out_bytes, then byte_count     last_of_item   truncated
// cfg       in         cfg_wdata_i = compressed_enable, written when cfg_we_i is high
//
// A control or literal byte is handled as it is taken; a repeat data byte is expanded into
// ceil(count/OUT_LANES) words, one per cycle while the single output register is free.
// The output register takes a new word in the cycle its current word is taken.
// Reset sets compressed_enable and returns the decoder to expect a control byte.
// A stalled output holds the input off until the output register frees up.
module run_length_decoder_core import rld_pkg::*; #(
  parameter int unsigned OUT_LANES = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [7:0]            s_axis_tdata_i,   // in_byte
  input  logic                  s_axis_tlast_i,   // end_of_stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // out_bytes, byte_count, zero pad to whole bytes
  output logic [((OUT_LANES*BYTE_W+$clog2(OUT_LANES+1)+7)/8)*8-1:0] m_axis_tdata_o,
  output logic                  m_axis_tlast_o,   // last_of_item
  output logic                  m_axis_tuser_o    // truncated
);

  localparam int unsigned DW = OUT_LANES * BYTE_W;
  localparam int unsigned CW = $clog2(OUT_LANES + 1);
  localparam int unsigned TW = ((DW + CW + 7) / 8) * 8;

  rld_cmd_t      cmd;
  rld_stat_t     stat;
  logic [DW-1:0] out_bytes;
  logic [CW-1:0] out_count;

  rld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_eos_i   (s_axis_tlast_i),
    .stat_i     (stat),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd)
  );

  rld_datapath #(
    .OUT_LANES (OUT_LANES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_byte_i   (s_axis_tdata_i),
    .out_ready_i (m_axis_tready_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid_o),
    .out_bytes_o (out_bytes),
    .out_count_o (out_count),
    .out_last_o  (m_axis_tlast_o),
    .out_trunc_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = TW'({out_count, out_bytes});

endmodule

@@ sv/rld_ctrl.sv @@
module rld_ctrl import rld_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_eos_i,
  input  rld_stat_t stat_i,
  output logic      in_ready_o,
  output rld_cmd_t  cmd_o
);

  localparam logic [1:0] ST_CTRL = 2'd0;
  localparam logic [1:0] ST_LIT  = 2'd1;
  localparam logic [1:0] ST_REP  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CTRL;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q != ST_EMIT) && stat_i.slot_free;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.out_sel = OUT_BYTE;
    if (state_q == ST_EMIT) begin
      // one word of the run per free output slot
      if (stat_i.slot_free) begin
        cmd_o.out_load = 1'b1;
        cmd_o.out_sel  = OUT_RUN;
        cmd_o.out_last = stat_i.run_le_lanes;
        cmd_o.run_step = 1'b1;
        if (stat_i.run_le_lanes) begin
          state_d = ST_CTRL;
        end
      end
    end else if (in_valid_i && in_ready_o) begin
      if (!stat_i.enable) begin
        cmd_o.out_load = 1'b1;
        cmd_o.out_last = 1'b1;
      end else begin
        unique case (state_q)
          ST_LIT: begin
            cmd_o.out_load  = 1'b1;
            cmd_o.out_last  = 1'b1;
            cmd_o.out_trunc = in_eos_i && !stat_i.cnt_is_one;
            cmd_o.cnt_dec   = 1'b1;
            if (stat_i.cnt_is_one) begin
              state_d = ST_CTRL;
            end
          end
          ST_REP: begin
            cmd_o.run_cap = 1'b1;
            state_d       = ST_EMIT;
          end
          default: begin
            cmd_o.cnt_load = 1'b1;
            state_d        = stat_i.ctl_is_rep ? ST_REP : ST_LIT;
            if (in_eos_i) begin
              cmd_o.out_load  = 1'b1;
              cmd_o.out_sel   = OUT_EMPTY;
              cmd_o.out_last  = 1'b1;
              cmd_o.out_trunc = 1'b1;
            end
          end
        endcase
      end
      // stream end resets the decoder, a repeat byte finishes its run first
      if (in_eos_i && !(stat_i.enable && state_q == ST_REP)) begin
        state_d         = ST_CTRL;
        cmd_o.cnt_clear = 1'b1;
      end
    end
  end

endmodule

@@ sv/rld_datapath.sv @@
module rld_datapath import rld_pkg::*; #(
  parameter int unsigned OUT_LANES = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_wdata_i,
  input  logic [BYTE_W-1:0]               in_byte_i,
  input  logic                            out_ready_i,
  input  rld_cmd_t                        cmd_i,
  output rld_stat_t                       stat_o,
  output logic                            out_valid_o,
  output logic [OUT_LANES*BYTE_W-1:0]     out_bytes_o,
  output logic [$clog2(OUT_LANES+1)-1:0]  out_count_o,
  output logic                            out_last_o,
  output logic                            out_trunc_o
);

  localparam int unsigned DW = OUT_LANES * BYTE_W;
  localparam int unsigned CW = $clog2(OUT_LANES + 1);

  logic              enable_q;
  logic [7:0]        cnt_q, cnt_d;
  logic [BYTE_W-1:0] run_byte_q;
  logic              out_valid_q;
  logic [DW-1:0]     bytes_q, bytes_d;
  logic [CW-1:0]     count_q, count_d;
  logic              last_q;
  logic              trunc_q;

  logic              run_le;
  logic [CW-1:0]     take;
  logic [DW-1:0]     run_word;

  assign run_le = (cnt_q <= 8'(OUT_LANES));
  assign take   = run_le ? cnt_q[CW-1:0] : CW'(OUT_LANES);

  always_comb begin
    for (int i = 0; i < OUT_LANES; i++) begin
      run_word[i*BYTE_W +: BYTE_W] = (CW'(i) < take) ? run_byte_q : '0;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clear) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_load) begin
      // literal: ctl+1, repeat: 1-ctl as a signed byte
      cnt_d = in_byte_i[7] ? (~in_byte_i + 8'd2) : (in_byte_i + 8'd1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - 8'd1;
    end else if (cmd_i.run_step) begin
      cnt_d = cnt_q - 8'(take);
    end
  end

  always_comb begin
    case (cmd_i.out_sel)
      OUT_RUN: begin
        bytes_d = run_word;
        count_d = take;
      end
      OUT_EMPTY: begin
        bytes_d = '0;
        count_d = '0;
      end
      default: begin
        bytes_d = DW'(in_byte_i);
        count_d = CW'(1);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b1;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
      cnt_q <= cnt_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.run_cap) begin
      run_byte_q <= in_byte_i;
    end
    if (cmd_i.out_load) begin
      bytes_q <= bytes_d;
      count_q <= count_d;
      last_q  <= cmd_i.out_last;
      trunc_q <= cmd_i.out_trunc;
    end
  end

  assign stat_o.enable       = enable_q;
  assign stat_o.slot_free    = !out_valid_q || out_ready_i;
  assign stat_o.cnt_is_one   = (cnt_q == 8'd1);
  assign stat_o.run_le_lanes = run_le;
  assign stat_o.ctl_is_rep   = in_byte_i[7];

  assign out_valid_o = out_valid_q;
  assign out_bytes_o = bytes_q;
  assign out_count_o = count_q;
  assign out_last_o  = last_q;
  assign out_trunc_o = trunc_q;

endmodule

@@ test/run_length_decoder_core_tb.sv @@
`timescale 1ns / 1ps

module run_length_decoder_core_tb;
  import rld_pkg::*;

  localparam int unsigned OUT_LANES = 4;
  localparam int unsigned WORD_W = OUT_LANES * BYTE_W;
  localparam int unsigned CNT_W = $clog2(OUT_LANES + 1);
  localparam int unsigned TDATA_W = ((WORD_W + CNT_W + 7) / 8) * 8;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned STALL_LIMIT = 2000;

  typedef enum logic [1:0] {
    ST_CTRL = 2'd0,
    ST_LIT  = 2'd1,
    ST_REP  = 2'd2
  } dec_state_e;

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } enc_byte_t;

  typedef struct packed {
    logic [WORD_W-1:0] bytes;
    logic [CNT_W-1:0]  count;
    logic              last;
    logic              trunc;
  } decoded_word_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_wdata_i = 1'b0;
  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  logic [7:0]         s_axis_tdata_i = '0;
  logic               s_axis_tlast_i = 1'b0;
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata_o;
  logic               m_axis_tlast_o;
  logic               m_axis_tuser_o;

  enc_byte_t     bytes_to_send[$];
  decoded_word_t words_due[$];

  // shadow of the decoder
  logic          dec_enable = 1'b1;
  dec_state_e    dec_state = ST_CTRL;
  logic [7:0]    dec_left = '0;

  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;
  int unsigned   mismatch_count = 0;
  int unsigned   stall_cycles = 0;
  logic          byte_taken = 1'b0;

  run_length_decoder_core #(
    .OUT_LANES(OUT_LANES)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void decode_byte(logic [7:0] b, logic eos);
    decoded_word_t w;
    int unsigned   left;
    int unsigned   cnt;
    w = '0;
    if (!dec_enable) begin
      w.bytes[BYTE_W-1:0] = b;
      w.count = CNT_W'(1);
      w.last = 1'b1;
      words_due.push_back(w);
    end else if (dec_state == ST_LIT) begin
      dec_left = dec_left - 8'd1;
      if (dec_left == 0) dec_state = ST_CTRL;
      w.bytes[BYTE_W-1:0] = b;
      w.count = CNT_W'(1);
      w.last = 1'b1;
      w.trunc = eos && (dec_left != 0);
      words_due.push_back(w);
    end else if (dec_state == ST_REP) begin
      // expand the run, full lanes first, remainder in the final word
      left = dec_left;
      while (left > 0) begin
        cnt = (left < OUT_LANES) ? left : OUT_LANES;
        w = '0;
        for (int i = 0; i < cnt; i++) w.bytes[i*BYTE_W +: BYTE_W] = b;
        left -= cnt;
        w.count = CNT_W'(cnt);
        w.last = (left == 0);
        words_due.push_back(w);
      end
      dec_state = ST_CTRL;
      dec_left = '0;
    end else begin
      if (!b[7]) begin
        dec_state = ST_LIT;
        dec_left = b + 8'd1;
      end else begin
        dec_state = ST_REP;
        dec_left = 8'd1 - b;
      end
      if (eos) begin
        w.last = 1'b1;
        w.trunc = 1'b1;
        words_due.push_back(w);
      end
    end
    if (eos) begin
      dec_state = ST_CTRL;
      dec_left = '0;
    end
  endfunction

  task automatic report_mismatch(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
    $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // driver: present the next item when the line is free or the last one was taken
  always @(negedge clk_i) begin
    enc_byte_t nxt;
    if (!s_axis_tvalid_i || byte_taken) begin
      if (bytes_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = bytes_to_send.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= nxt.data;
        s_axis_tlast_i <= nxt.eos;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor: check taken words, predict from taken items, watch for a hang
  always @(posedge clk_i) begin
    decoded_word_t want;
    logic          in_fire;
    logic          out_fire;
    in_fire = rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    out_fire = rst_ni && m_axis_tvalid_o && m_axis_tready_i;
    byte_taken <= in_fire;
    if (out_fire) begin
      if (words_due.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata_o[WORD_W-1:0], '0);
      end else begin
        want = words_due.pop_front();
        if (m_axis_tdata_o[WORD_W-1:0] !== want.bytes)
          report_mismatch("out_bytes", m_axis_tdata_o[WORD_W-1:0], want.bytes);
        if (m_axis_tdata_o[WORD_W +: CNT_W] !== want.count)
          report_mismatch("byte_count", WORD_W'(m_axis_tdata_o[WORD_W +: CNT_W]),
                          WORD_W'(want.count));
        if (m_axis_tlast_o !== want.last)
          report_mismatch("last_of_item", WORD_W'(m_axis_tlast_o), WORD_W'(want.last));
        if (m_axis_tuser_o !== want.trunc)
          report_mismatch("truncated", WORD_W'(m_axis_tuser_o), WORD_W'(want.trunc));
      end
    end
    if (in_fire) decode_byte(s_axis_tdata_i, s_axis_tlast_i);
    if (in_fire || out_fire || !rst_ni) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t ns: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic queue_byte(logic [7:0] data, logic eos);
    enc_byte_t e;
    e.data = data;
    e.eos = eos;
    bytes_to_send.push_back(e);
  endtask

  // one well-formed stream of a few packets, sometimes cut short
  task automatic queue_stream();
    int unsigned packets;
    int unsigned r;
    int unsigned len;
    int unsigned cut;
    packets = $urandom_range(1, 4);
    for (int p = 0; p < packets; p++) begin
      r = $urandom_range(99);
      if (r < 42) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 4);
        queue_byte(8'(len - 1), 1'b0);
        for (int i = 0; i < len; i++) queue_byte(8'($urandom), 1'b0);
      end else if (r < 84) begin
        len = ($urandom_range(14) == 0) ? $urandom_range(100, 129) : $urandom_range(2, 11);
        queue_byte(8'(257 - len), 1'b0);
        queue_byte(8'($urandom), 1'b0);
      end else if (r < 92) begin
        // end on a control byte
        queue_byte(8'($urandom), 1'b1);
        return;
      end else begin
        // end inside a literal run
        len = $urandom_range(2, 6);
        cut = $urandom_range(1, len - 1);
        queue_byte(8'(len - 1), 1'b0);
        for (int i = 0; i < cut; i++) queue_byte(8'($urandom), i == cut - 1);
        return;
      end
    end
    bytes_to_send[bytes_to_send.size()-1].eos = 1'b1;
  endtask

  task automatic queue_coded(int unsigned n);
    int unsigned start;
    start = bytes_to_send.size();
    while (bytes_to_send.size() < start + n) begin
      if ($urandom_range(9) == 0) queue_byte(8'($urandom), $urandom_range(3) == 0);
      else queue_stream();
    end
  endtask

  task automatic write_enable(logic value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    dec_enable = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // hold until every item is taken and every word has come out
  task automatic drain();
    while (bytes_to_send.size() != 0 || s_axis_tvalid_i || words_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // decoding, light sender gaps, heavy receiver stalls
    send_idle_pct = 9;
    recv_idle_pct = 54;
    write_enable(1'b1);
    queue_byte(8'h00, 1'b0); queue_byte(8'hAB, 1'b0);   // single literal
    queue_byte(8'hFF, 1'b0); queue_byte(8'h00, 1'b0);   // shortest repeat
    queue_byte(8'h80, 1'b0); queue_byte(8'hFF, 1'b0);   // longest repeat
    queue_byte(8'hFD, 1'b0); queue_byte(8'h5A, 1'b0);   // exactly one full word
    queue_byte(8'hFC, 1'b0); queue_byte(8'hC3, 1'b0);   // one byte past a full word
    queue_byte(8'h7F, 1'b0); queue_byte(8'h11, 1'b0);   // longest literal, cut short
    queue_byte(8'h22, 1'b1);
    queue_byte(8'h03, 1'b1);                            // stream ends on literal control
    queue_byte(8'h85, 1'b1);                            // stream ends on repeat control
    queue_byte(8'hFE, 1'b0); queue_byte(8'h77, 1'b1);   // repeat completes at stream end
    queue_byte(8'h01, 1'b0); queue_byte(8'h33, 1'b0);   // literal completes at stream end
    queue_byte(8'h44, 1'b1);
    queue_coded(35);
    queue_byte(8'h02, 1'b0);                            // leave a literal run open
    drain();

    // pass-through, heavy sender gaps, light receiver stalls
    send_idle_pct = 54;
    recv_idle_pct = 9;
    write_enable(1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h7F, 1'b0);
    for (int i = 0; i < 20; i++) queue_byte(8'($urandom), $urandom_range(7) == 0);
    drain();

    // decoding again, no gaps at all
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_enable(1'b1);
    queue_coded(35);
    drain();

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/rld_pkg.sv
sv/rld_ctrl.sv
sv/rld_datapath.sv
sv/run_length_decoder_core.sv
test/run_length_decoder_core_tb.sv
